// ----- rtl/core/dtfp_pkg.sv -----
// Shared types, character codes and constant helpers for the decimal text
// to fixed point converter. No dependencies.
`default_nettype none

package dtfp_pkg;

  // Parameter defaults and ranges
  localparam int FRAC_BITS_DEF       = 16;
  localparam int MAX_FRAC_DIGITS_DEF = 6;
  localparam int FRAC_BITS_MIN       = 8;
  localparam int MAX_FRAC_DIGITS_MAX = 7;

  // Queue between the parser and the scaler
  localparam int QUEUE_DEPTH = 4;

  // Widest fields a parsed request can carry over the whole parameter range
  localparam int INT_W_MAX  = 31 - FRAC_BITS_MIN;
  localparam int FRAC_W_MAX = 24;
  localparam int CNT_W_MAX  = 3;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_text;
  } dtfp_in_t;

  typedef struct packed {
    logic signed [31:0] fixed_value;
    logic               saturated;
  } dtfp_out_t;

  // One finished parse, handed from the parser to the scaler
  typedef struct packed {
    logic [INT_W_MAX-1:0]  int_mag;
    logic [FRAC_W_MAX-1:0] frac_mag;
    logic [CNT_W_MAX-1:0]  frac_cnt;
    logic                  neg;
    logic                  ovf;
  } dtfp_rec_t;

  // 10 to the n, 1 for n below one; elaboration-time use only
  function automatic longint unsigned pow10(input int n);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * 10;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/dtfp_front.sv -----
// Character parser: skips blanks, takes the sign, accumulates integer and
// fraction digits and emits one request per text. Depends on dtfp_pkg.
`default_nettype none

module dtfp_front
  import dtfp_pkg::*;
#(
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire dtfp_in_t  in_data,
  input  wire logic      q_full,
  output logic           push,
  output dtfp_rec_t      push_rec
);

  localparam int INT_W  = 31 - FRAC_BITS;
  localparam int FRAC_W = $clog2(pow10(MAX_FRAC_DIGITS));
  localparam int CNT_W  = $clog2(MAX_FRAC_DIGITS + 1);
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_FRAC_DIGITS);

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_INT,
    PH_FRAC,
    PH_DONE
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic              neg_r, neg_nxt;
  logic              ovf_r, ovf_nxt;
  logic [INT_W-1:0]  int_r, int_nxt;
  logic [FRAC_W-1:0] frac_r, frac_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;

  logic              accept;
  logic              is_digit, is_blank;
  logic [3:0]        digit;
  logic [INT_W+3:0]  int_sum;
  logic              int_add, frac_add;

  assign accept   = in_valid && !q_full;
  assign is_digit = (in_data.char_byte >= CH_ZERO) && (in_data.char_byte <= CH_NINE);
  assign is_blank = (in_data.char_byte == CH_SPACE) ||
                    ((in_data.char_byte >= CH_TAB) && (in_data.char_byte <= CH_CR));
  assign digit    = 4'(in_data.char_byte - CH_ZERO);
  assign int_sum  = (INT_W+4)'(int_r) * (INT_W+4)'(10) + (INT_W+4)'(digit);

  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    int_add   = 1'b0;
    frac_add  = 1'b0;
    case (phase_r)
      PH_SKIP: begin
        if (is_blank) begin
          phase_nxt = PH_SKIP;
        end else if (in_data.char_byte == CH_MINUS) begin
          neg_nxt   = 1'b1;
          phase_nxt = PH_INT;
        end else if (in_data.char_byte == CH_PLUS) begin
          phase_nxt = PH_INT;
        end else if (is_digit) begin
          int_add   = 1'b1;
          phase_nxt = PH_INT;
        end else if (in_data.char_byte == CH_POINT) begin
          phase_nxt = PH_FRAC;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      PH_INT: begin
        if (is_digit) begin
          int_add = 1'b1;
        end else if (in_data.char_byte == CH_POINT) begin
          phase_nxt = PH_FRAC;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      PH_FRAC: begin
        if (is_digit) begin
          frac_add = 1'b1;
        end else begin
          phase_nxt = PH_DONE;
        end
      end
      default: begin
        phase_nxt = phase_r;
      end
    endcase

    // Integer digit: clamp at the all-ones limit once the sum leaves range
    int_nxt = int_r;
    ovf_nxt = ovf_r;
    if (int_add) begin
      if (int_sum[INT_W+3:INT_W] != 4'd0) begin
        int_nxt = '1;
        ovf_nxt = 1'b1;
      end else begin
        int_nxt = int_sum[INT_W-1:0];
      end
    end

    // Fraction digit: drop digits past the kept count
    frac_nxt = frac_r;
    cnt_nxt  = cnt_r;
    if (frac_add && (cnt_r < CNT_LIMIT)) begin
      frac_nxt = FRAC_W'(frac_r * FRAC_W'(10)) + FRAC_W'(digit);
      cnt_nxt  = cnt_r + CNT_W'(1);
    end
  end

  assign push              = accept && in_data.end_of_text;
  assign push_rec.int_mag  = INT_W_MAX'(int_nxt);
  assign push_rec.frac_mag = FRAC_W_MAX'(frac_nxt);
  assign push_rec.frac_cnt = CNT_W_MAX'(cnt_nxt);
  assign push_rec.neg      = neg_nxt;
  assign push_rec.ovf      = ovf_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP;
      neg_r   <= 1'b0;
      ovf_r   <= 1'b0;
      int_r   <= '0;
      frac_r  <= '0;
      cnt_r   <= '0;
    end else if (accept) begin
      if (in_data.end_of_text) begin
        // Text done: return to the initial parse state
        phase_r <= PH_SKIP;
        neg_r   <= 1'b0;
        ovf_r   <= 1'b0;
        int_r   <= '0;
        frac_r  <= '0;
        cnt_r   <= '0;
      end else begin
        phase_r <= phase_nxt;
        neg_r   <= neg_nxt;
        ovf_r   <= ovf_nxt;
        int_r   <= int_nxt;
        frac_r  <= frac_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dtfp_queue.sv -----
// Short request queue between parser and scaler, so each side can stall
// on its own. Depends on dtfp_pkg.
`default_nettype none

module dtfp_queue
  import dtfp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire dtfp_rec_t push_rec,
  output logic           full,
  input  wire logic      pop,
  output logic           pop_valid,
  output dtfp_rec_t      pop_rec
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  dtfp_rec_t         mem_r [0:QUEUE_DEPTH-1];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_rec   = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/dtfp_back.sv -----
// Scaler: aligns the kept fraction to a fixed digit count, scales it to
// FRAC_BITS by a reciprocal multiply for the matching power of ten and forms
// the signed result in an output register. Depends on dtfp_pkg.
`default_nettype none

module dtfp_back
  import dtfp_pkg::*;
#(
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      q_valid,
  input  wire dtfp_rec_t q_rec,
  output logic           q_pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output dtfp_out_t      out_data
);

  localparam int INT_W  = 31 - FRAC_BITS;
  localparam int FRAC_W = $clog2(pow10(MAX_FRAC_DIGITS));
  localparam int CNT_W  = $clog2(MAX_FRAC_DIGITS + 1);
  localparam int TBL_N  = 1 << CNT_W;

  // 10^D = 5^D * 2^D, so X * 2^FRAC_BITS / 10^D = X * 2^(FRAC_BITS-D) / 5^D.
  // The reciprocal ceil(2^(FRAC_BITS+LOG25) / 5^D) is exact for every
  // aligned fraction X below 10^D since 2^LOG25 >= 25^D.
  localparam longint unsigned POW5 = pow10(MAX_FRAC_DIGITS) >> MAX_FRAC_DIGITS;
  localparam int LOG25 = $clog2(POW5 * POW5);
  localparam int RSH   = LOG25 + MAX_FRAC_DIGITS;
  localparam int PW    = RSH + FRAC_BITS;
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << (FRAC_BITS + LOG25)) + POW5 - 64'd1) / POW5;
  localparam logic [PW-1:0] RECIP = PW'(RECIP_VAL);

  logic [FRAC_W-1:0]    scale_tbl [0:TBL_N-1];
  logic [CNT_W-1:0]     cnt;
  logic [FRAC_W-1:0]    aligned;
  logic [PW-1:0]        recip_prod;

  logic                 adv;
  logic                 s1_valid_r, s2_valid_r, out_valid_r;
  logic [FRAC_W-1:0]    s1_frac_r;
  logic [INT_W-1:0]     s1_int_r, s2_int_r;
  logic                 s1_neg_r, s2_neg_r;
  logic                 s1_ovf_r, s2_ovf_r;
  logic [FRAC_BITS-1:0] s2_quo_r;
  dtfp_out_t            out_data_r;
  logic [FRAC_BITS-1:0] frac_f;
  logic [31:0]          mag;

  // Bring every fraction to the full digit count: F * 10^(max - n)
  always_comb begin
    for (int i = 0; i < TBL_N; i++) begin
      scale_tbl[i] = FRAC_W'(pow10(MAX_FRAC_DIGITS - i));
    end
  end

  assign cnt     = q_rec.frac_cnt[CNT_W-1:0];
  assign aligned = q_rec.frac_mag[FRAC_W-1:0] * scale_tbl[cnt];

  // Truncating scale by the reciprocal; the top bits are the quotient
  assign recip_prod = PW'(s1_frac_r) * RECIP;

  // Advance the whole pipeline whenever the output register can take a result
  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && q_valid;

  assign frac_f = s2_ovf_r ? '1 : s2_quo_r;
  assign mag    = {1'b0, s2_int_r, frac_f};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= q_valid;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_frac_r <= aligned;
      s1_int_r  <= q_rec.int_mag[INT_W-1:0];
      s1_neg_r  <= q_rec.neg;
      s1_ovf_r  <= q_rec.ovf;
      s2_quo_r  <= recip_prod[PW-1:RSH];
      s2_int_r  <= s1_int_r;
      s2_neg_r  <= s1_neg_r;
      s2_ovf_r  <= s1_ovf_r;
      out_data_r.fixed_value <= s2_neg_r ? $signed(32'd0 - mag) : $signed(mag);
      out_data_r.saturated   <= s2_ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ----- rtl/core/decimal_text_to_fixed_point.sv -----
// Decimal text to signed fixed point converter, top level.
// Instantiates dtfp_front, dtfp_queue and dtfp_back; uses dtfp_pkg.
//
// Usage:
//   The input channel carries one ASCII character per request (char_byte)
//   with end_of_text marking the last character of a number. The parser
//   skips leading blanks, takes an optional sign, integer digits, an
//   optional point and fraction digits; the first character that fits none
//   of these ends the parse and later characters of the same text are
//   ignored. Only the last character of a text produces a result request:
//   the value in two's complement with FRAC_BITS fraction bits, and
//   saturated when the integer part was clamped.
// Throughput: one character per cycle while in_stall is low, also across texts.
// Path: after the last character is accepted, its request is written to the
//   queue and then captured in turn by the fraction alignment stage, the
//   reciprocal multiply stage and the output register, which drives out_valid.
// Stall: out_stall holds the output register and the scaler; the parser
//   keeps accepting until the four-entry queue fills, then raises in_stall.
// Reset: synchronous, active low; clears the parse state, empties the
//   queue and drops any result in flight.
`default_nettype none

module decimal_text_to_fixed_point
  import dtfp_pkg::*;
#(
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire dtfp_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output dtfp_out_t      out_data
);

  logic      q_full;
  logic      push;
  dtfp_rec_t push_rec;
  logic      q_pop;
  logic      q_valid;
  dtfp_rec_t q_rec;

  // Stall characters only while the request queue is full
  assign in_stall = q_full;

  dtfp_front #(
    .FRAC_BITS       (FRAC_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  dtfp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_rec   (q_rec)
  );

  dtfp_back #(
    .FRAC_BITS       (FRAC_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_rec     (q_rec),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- rtl/core/dtfp_checker.sv -----
// Port-level checks for decimal_text_to_fixed_point, attached by bind.
// Depends on dtfp_pkg.
`default_nettype none

module dtfp_checker
  import dtfp_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire dtfp_out_t out_data
);

  // Drop any result in flight at reset
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A saturated result is the clamped full-scale magnitude
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.saturated |->
      (out_data.fixed_value == 32'sh7FFFFFFF) || (out_data.fixed_value == 32'sh80000001))
    else $error("saturated result is not full scale");

  // Hold a stalled result
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result changed while stalled");

endmodule

bind decimal_text_to_fixed_point dtfp_checker u_dtfp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ----- sim/decimal_text_to_fixed_point_test.sv -----
// Self-checking testbench for decimal_text_to_fixed_point: drives character
// requests and checks each fixed point result against an in-bench parser.
// Depends on dtfp_pkg and the decimal_text_to_fixed_point RTL only.
`timescale 1ns / 100ps

module decimal_text_to_fixed_point_test;
  import dtfp_pkg::*;

  typedef logic [7:0] char_t;

  typedef enum logic [1:0] {
    SKIP_BLANKS,
    INT_DIGITS,
    FRAC_DIGITS,
    PARSE_DONE
  } parse_phase_t;

  // Largest integer magnitude before the block clamps
  localparam int unsigned INT_MAG_MAX = (1 << (31 - FRAC_BITS_DEF)) - 1;
  localparam longint unsigned TEN_POW [0:7] = '{
    64'd1, 64'd10, 64'd100, 64'd1000, 64'd10000, 64'd100000, 64'd1000000,
    64'd10000000
  };
  localparam char_t BLANK_CHARS [0:5] = '{
    CH_TAB, 8'h0A, 8'h0B, 8'h0C, CH_CR, CH_SPACE
  };
  localparam int CHAR_TARGET = 1800;
  localparam int SETTLE_CYCLES = 4 * (FRAC_BITS_DEF + 2);

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  dtfp_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  dtfp_out_t out_data;

  // Idle controls, changed per test: longest gap each side draws, and a
  // one-shot long hold-off for the result side
  int tx_max_gap = 0;
  int rx_max_gap = 0;
  int rx_hold_len = 0;

  int error_count = 0;
  int chars_sent = 0;

  // Parser state mirrored from the block
  parse_phase_t parse_state = SKIP_BLANKS;
  logic         neg_seen = 1'b0;
  int unsigned  int_mag = 0;
  int unsigned  frac_mag = 0;
  int           frac_cnt = 0;
  logic         clamped = 1'b0;

  dtfp_out_t expected_values [$];
  char_t     text_chars [$];

  decimal_text_to_fixed_point #(
    .FRAC_BITS      (FRAC_BITS_DEF),
    .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS_DEF)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Parser mirror
  // ---------------------------------------------------------------------

  function automatic logic is_digit_char(input char_t ch);
    return ch >= CH_ZERO && ch <= CH_NINE;
  endfunction

  function automatic void clear_parse();
    parse_state = SKIP_BLANKS;
    neg_seen    = 1'b0;
    int_mag     = 0;
    frac_mag    = 0;
    frac_cnt    = 0;
    clamped     = 1'b0;
  endfunction

  // Accumulate one integer digit; clamp at the top of the integer range
  function automatic void add_int_digit(input char_t ch);
    int unsigned int_next;
    int_next = int_mag * 10 + int'(ch - CH_ZERO);
    if (int_next > INT_MAG_MAX) begin
      int_mag = INT_MAG_MAX;
      clamped = 1'b1;
    end else begin
      int_mag = int_next;
    end
  endfunction

  // Advance the parse by one accepted character; on end of text, queue the
  // value the block must produce and start over
  function automatic void parse_character(input dtfp_in_t req);
    char_t           ch;
    logic            blank;
    longint unsigned frac_q;
    longint unsigned mag;
    logic [31:0]     word;
    dtfp_out_t       res;
    ch = req.char_byte;
    blank = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
    case (parse_state)
      SKIP_BLANKS: begin
        if (!blank) begin
          if (ch == CH_MINUS) begin
            neg_seen = 1'b1;
            parse_state = INT_DIGITS;
          end else if (ch == CH_PLUS) begin
            parse_state = INT_DIGITS;
          end else if (is_digit_char(ch)) begin
            add_int_digit(ch);
            parse_state = INT_DIGITS;
          end else if (ch == CH_POINT) begin
            parse_state = FRAC_DIGITS;
          end else begin
            parse_state = PARSE_DONE;
          end
        end
      end
      INT_DIGITS: begin
        if (is_digit_char(ch)) begin
          add_int_digit(ch);
        end else if (ch == CH_POINT) begin
          parse_state = FRAC_DIGITS;
        end else begin
          parse_state = PARSE_DONE;
        end
      end
      FRAC_DIGITS: begin
        // Drop digits past the kept count, but keep parsing
        if (is_digit_char(ch)) begin
          if (frac_cnt < MAX_FRAC_DIGITS_DEF) begin
            frac_mag = frac_mag * 10 + int'(ch - CH_ZERO);
            frac_cnt++;
          end
        end else begin
          parse_state = PARSE_DONE;
        end
      end
      default: begin
      end
    endcase

    if (req.end_of_text) begin
      // Clamped values carry an all-ones fraction; otherwise scale and
      // truncate the kept digits
      if (clamped) begin
        frac_q = (64'd1 << FRAC_BITS_DEF) - 64'd1;
      end else begin
        frac_q = (64'(frac_mag) << FRAC_BITS_DEF) / TEN_POW[frac_cnt];
      end
      mag = (64'(int_mag) << FRAC_BITS_DEF) + frac_q;
      word = {1'b0, mag[30:0]};
      // Apply the sign last so that negative zero comes out as zero
      if (neg_seen) begin
        word = -word;
      end
      res.fixed_value = word;
      res.saturated = clamped;
      expected_values.push_back(res);
      clear_parse();
    end
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus side
  // ---------------------------------------------------------------------

  // Offer one character request after a random gap; hold it until taken
  task automatic send_char(input char_t ch, input logic last);
    dtfp_in_t req;
    int       gap;
    req.char_byte = ch;
    req.end_of_text = last;
    gap = $urandom_range(0, tx_max_gap);
    repeat (gap) @(negedge clk) in_valid <= 1'b0;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    parse_character(req);
    chars_sent++;
  endtask

  task automatic send_string(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(char_t'(s[i]), i == s.len() - 1);
    end
  endtask

  task automatic send_text();
    foreach (text_chars[i]) begin
      send_char(text_chars[i], i == text_chars.size() - 1);
    end
  endtask

  function automatic void push_digit();
    text_chars.push_back(char_t'(CH_ZERO + $urandom_range(0, 9)));
  endfunction

  function automatic void push_any();
    text_chars.push_back(char_t'($urandom_range(0, 255)));
  endfunction

  // Build one random text: mostly well-formed numbers with random content,
  // some broken sequences of number characters, some pure noise
  function automatic void make_text();
    int kind;
    text_chars.delete();
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      repeat ($urandom_range(0, 2)) text_chars.push_back(BLANK_CHARS[$urandom_range(0, 5)]);
      case ($urandom_range(0, 2))
        1: text_chars.push_back(CH_MINUS);
        2: text_chars.push_back(CH_PLUS);
        default: begin
        end
      endcase
      if ($urandom_range(0, 9) == 0) begin
        // Land right around the clamp boundary
        text_chars.push_back(char_t'(CH_ZERO + 3));
        text_chars.push_back(char_t'(CH_ZERO + 2));
        text_chars.push_back(char_t'(CH_ZERO + 7));
        text_chars.push_back(char_t'(CH_ZERO + 6));
        push_digit();
      end else begin
        repeat (($urandom_range(0, 7) == 0) ? $urandom_range(6, 8) : $urandom_range(0, 4))
          push_digit();
      end
      if ($urandom_range(0, 2) != 0) begin
        text_chars.push_back(CH_POINT);
        repeat ($urandom_range(0, 9)) push_digit();
      end
      repeat ($urandom_range(0, 2)) push_any();
      if (text_chars.size() == 0) begin
        push_digit();
      end
    end else if (kind < 85) begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 5))
          0: text_chars.push_back(CH_MINUS);
          1: text_chars.push_back(CH_PLUS);
          2: text_chars.push_back(CH_POINT);
          3: text_chars.push_back(CH_SPACE);
          4: push_digit();
          default: push_any();
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 6)) push_any();
    end
  endfunction

  // Drop valid and wait for every queued result to come back
  task automatic finish_texts();
    @(negedge clk) in_valid <= 1'b0;
    while (expected_values.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------

  // Stall before each result for a random count, or for the long hold-off
  // when one is requested
  initial begin : result_receiver
    int stall_len;
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      if (rx_hold_len > 0) begin
        stall_len = rx_hold_len;
        rx_hold_len = 0;
      end else begin
        stall_len = $urandom_range(0, rx_max_gap);
      end
      repeat (stall_len) @(negedge clk) out_stall <= 1'b1;
      @(negedge clk) out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  // Compare every accepted result with the oldest pending value
  always @(posedge clk) begin : result_check
    dtfp_out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_values.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result: expected none, actual value %h saturated %b",
                 $time, out_data.fixed_value, out_data.saturated);
      end else begin
        want = expected_values.pop_front();
        if (out_data.fixed_value !== want.fixed_value) begin
          error_count++;
          $display("%0t: fixed_value mismatch: expected %h, actual %h",
                   $time, want.fixed_value, out_data.fixed_value);
        end
        if (out_data.saturated !== want.saturated) begin
          error_count++;
          $display("%0t: saturated mismatch: expected %b, actual %b",
                   $time, want.saturated, out_data.saturated);
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Hand-picked texts covering each parse rule and the byte extremes
  task automatic test_directed();
    tx_max_gap = 8;
    rx_max_gap = 8;
    // blank, minus, point with no integer digits, trailing junk ignored
    send_string("\t-.5x");
    // sign with no digits
    send_string("+");
    // integer overflow clamps
    send_string("99999");
    // negative zero
    send_string("-0");
    // fraction digits past the kept count
    send_string(".1234567");
    // whitespace only
    send_string(" ");
    // characters that end the parse at once
    send_char(8'h00, 1'b1);
    send_char(8'hFF, 1'b1);
    finish_texts();
  endtask

  // Full rate on both sides: last character of one text directly followed
  // by the first of the next
  task automatic test_back_to_back();
    int stop_at;
    tx_max_gap = 0;
    rx_max_gap = 0;
    stop_at = chars_sent + 200;
    while (chars_sent < stop_at) begin
      make_text();
      send_text();
    end
    finish_texts();
  endtask

  // Hold off the result side for a long stretch while texts keep coming,
  // so the queue fills and the input stalls
  task automatic test_queue_fill();
    tx_max_gap = 0;
    rx_max_gap = 0;
    rx_hold_len = 400;
    repeat (40) begin
      make_text();
      send_text();
    end
    finish_texts();
  endtask

  // Bulk random texts with random gaps on both sides; every eighth batch runs
  // without idling
  task automatic test_random_texts();
    int batch;
    batch = 0;
    while (chars_sent < CHAR_TARGET) begin
      if (batch % 8 == 7) begin
        tx_max_gap = 0;
        rx_max_gap = 0;
      end else begin
        tx_max_gap = 8;
        rx_max_gap = 8;
      end
      repeat (10) begin
        make_text();
        send_text();
      end
      batch++;
    end
    finish_texts();
  endtask

  initial begin
    clear_parse();
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_directed();
    test_back_to_back();
    test_queue_fill();
    test_random_texts();

    // Let any stray result surface before the verdict
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_values.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (expected_values.size() != 0) begin
        $display("%0t: %0d results never arrived: expected value %h, actual none",
                 $time, expected_values.size(), expected_values[0].fixed_value);
      end
      $display("TEST FAILED");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run
  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
